@@ sv/prfs_pkg.sv @@
// Shared types, constants and fixed-point helpers for the secant root finder.
package prfs_pkg;

   localparam int MAX_DEGREE = 5;
   localparam int FRAC_BITS  = 32;
   localparam int DEPTH      = MAX_DEGREE + 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int WORD_W     = 64;
   localparam int WIDE_W     = 2 * WORD_W;
   localparam int TOL_W      = 33;
   localparam int STEP_W     = 6;
   localparam int ROOT_W     = 4;
   localparam int DIV_CNT_W  = $clog2(WIDE_W);
   localparam int CSR_ADDR_W = 2;

   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_START_FIRST  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_SECOND = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOLERANCE    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ITER_LIMIT   = 2'd3;

   localparam logic [WORD_W-1:0] RST_START_FIRST  = 64'd0;
   localparam logic [WORD_W-1:0] RST_START_SECOND = 64'd429496730;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 33'd430;
   localparam logic [STEP_W-1:0] RST_ITER_LIMIT   = 6'd29;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_RUN_START,
      DP_ROOT_INIT,
      DP_HORNER_INIT,
      DP_MUL_START,
      DP_MUL_STEP,
      DP_HORNER_ACC,
      DP_SAVE_V_PREV,
      DP_SAVE_V_CUR,
      DP_DEN,
      DP_DIV_START,
      DP_DIV_STEP,
      DP_NEXT,
      DP_ADVANCE,
      DP_EMIT_DEFLATE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      mul_secant;   // multiplier operands: 1 secant, 0 Horner
   } dp_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic idx_zero;
      logic mul_last;
      logic div_last;
      logic den_zero;
      logic limit_hit;
      logic conv;
      logic out_busy;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RUN,
      S_ROOT,
      S_H_INIT,
      S_H_MUL,
      S_H_WAIT,
      S_H_ACC,
      S_SAVE,
      S_TEST,
      S_CHECK,
      S_CHECK2,
      S_S_MUL,
      S_S_WAIT,
      S_DIV_START,
      S_DIV,
      S_NEXT,
      S_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_PREV,
      PH_CUR,
      PH_NEXT
   } eval_phase_type;

   function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
      return s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] sat_sub(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? WORD_MIN : WORD_MAX;
      return s[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] mag(logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (~v + 64'd1) : v;
   endfunction

   // signed word from sign and 128-bit magnitude, saturated
   function automatic logic [WORD_W-1:0] from_mag(logic neg, logic [WIDE_W-1:0] m);
      if (neg) begin
         if (m > {{WORD_W{1'b0}}, WORD_MIN}) return WORD_MIN;
         return ~m[WORD_W-1:0] + 64'd1;
      end
      if (m > {{WORD_W{1'b0}}, WORD_MAX}) return WORD_MAX;
      return m[WORD_W-1:0];
   endfunction

endpackage

@@ sv/polynomial_root_finder_secant.sv @@
// Top level of the secant root finder with Horner deflation.
// Coefficients arrive lowest degree first; the request marked last starts a search that
// yields one result per degree (none for a constant). The block takes no request while
// searching. Each Horner pass of degree n has a set-up step, then per term a multiply
// start, a multiply built from 32x32 partial products and an accumulate, then a save
// step; each secant step adds a one-bit-a-cycle restoring divide plus one Horner pass.
// A root costs two Horner passes plus up to iteration_limit steps, and its emit waits
// while the previous result is not yet taken; loading takes one coefficient per cycle.
module polynomial_root_finder_secant
   import prfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // [63:0] coefficient
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [143:0]          rsp_tdata,   // [63:0] root, [127:64] residual,
                                              // [133:128] iterations, [137:134] root_number
   output logic                  rsp_tuser,   // [0] converged
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [WORD_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   prfs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   prfs_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .coefficient (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ sv/prfs_datapath.sv @@
// Datapath: coefficient stores, secant registers, multiplier, divider, result register.
module prfs_datapath
   import prfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [WORD_W-1:0]     csr_wdata,
   input  logic [WORD_W-1:0]     coefficient,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [143:0]          rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [WORD_W-1:0] start_first_ff, start_second_ff;
   logic [TOL_W-1:0]  tolerance_ff;
   logic [STEP_W-1:0] limit_ff;

   logic [WORD_W-1:0] c_ff [DEPTH];
   logic [WORD_W-1:0] q_ff [DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  n_ff, idx_ff;
   logic [ROOT_W-1:0] root_ctr_ff;
   logic [STEP_W-1:0] steps_ff;
   logic              conv_ff;

   logic [WORD_W-1:0] x_prev_ff, x_cur_ff, v_prev_ff, v_cur_ff, x_eval_ff, acc_ff, den_ff;

   logic [WORD_W-1:0] mul_a_ff, mul_b_ff;
   logic              mul_neg_ff, corr_neg_ff;
   logic [1:0]        mul_k_ff;
   logic [WIDE_W-1:0] prod_ff;
   logic [WORD_W-1:0] rem_ff, dv_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic              rsp_valid_ff;
   logic [143:0]      rsp_data_ff;
   logic              rsp_user_ff, rsp_last_ff;

   logic [WORD_W-1:0] fx_val, horner_val, d_val, op_a, op_b, corr, x_next, step;
   logic [63:0]       pp;
   logic [WIDE_W-1:0] pp_shifted;
   logic [WORD_W:0]   rem_sh;
   logic              ge;

   // fixed-point product of the finished multiply, then Horner add
   assign fx_val     = from_mag(mul_neg_ff, prod_ff >> FRAC_BITS);
   assign horner_val = sat_add(c_ff[idx_ff], fx_val);
   assign d_val      = sat_sub(x_cur_ff, x_prev_ff);
   assign op_a       = cmd.mul_secant ? v_cur_ff : x_eval_ff;
   assign op_b       = cmd.mul_secant ? d_val : acc_ff;

   // one 32x32 partial product per cycle
   always_comb begin
      pp = (mul_k_ff[1] ? {32'd0, mul_a_ff[63:32]} : {32'd0, mul_a_ff[31:0]})
         * (mul_k_ff[0] ? {32'd0, mul_b_ff[63:32]} : {32'd0, mul_b_ff[31:0]});
      case (mul_k_ff)
         2'd0:    pp_shifted = {64'd0, pp};
         2'd3:    pp_shifted = {pp, 64'd0};
         default: pp_shifted = {32'd0, pp, 32'd0};
      endcase
   end

   // restoring divide step
   assign rem_sh = {rem_ff, prod_ff[WIDE_W-1]};
   assign ge     = rem_sh >= {1'b0, dv_ff};

   assign corr   = from_mag(corr_neg_ff, prod_ff);
   assign x_next = sat_sub(x_cur_ff, corr);
   assign step   = sat_sub(x_eval_ff, x_cur_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_first_ff  <= RST_START_FIRST;
         start_second_ff <= RST_START_SECOND;
         tolerance_ff    <= RST_TOLERANCE;
         limit_ff        <= RST_ITER_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START_FIRST:  start_first_ff  <= csr_wdata;
            CSR_START_SECOND: start_second_ff <= csr_wdata;
            CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[TOL_W-1:0];
            CSR_ITER_LIMIT:   limit_ff        <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // control counters and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         n_ff         <= '0;
         root_ctr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (cmd.op)
            DP_LOAD: if (count_ff < CNT_W'(DEPTH)) count_ff <= count_ff + 1'b1;
            DP_RUN_START: begin
               n_ff        <= IDX_W'(count_ff - 1'b1);
               count_ff    <= '0;
               root_ctr_ff <= '0;
            end
            DP_EMIT_DEFLATE: begin
               rsp_valid_ff <= 1'b1;
               n_ff         <= n_ff - 1'b1;
               root_ctr_ff  <= root_ctr_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_LOAD: if (count_ff < CNT_W'(DEPTH)) c_ff[IDX_W'(count_ff)] <= coefficient;
         DP_ROOT_INIT: begin
            x_prev_ff <= start_first_ff;
            x_cur_ff  <= start_second_ff;
            x_eval_ff <= start_first_ff;
            steps_ff  <= '0;
            conv_ff   <= 1'b0;
         end
         DP_HORNER_INIT: begin
            acc_ff <= '0;
            idx_ff <= n_ff;
         end
         DP_MUL_START: begin
            mul_a_ff   <= mag(op_a);
            mul_b_ff   <= mag(op_b);
            mul_neg_ff <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
            mul_k_ff   <= '0;
            prod_ff    <= '0;
         end
         DP_MUL_STEP: begin
            prod_ff  <= prod_ff + pp_shifted;
            mul_k_ff <= mul_k_ff + 1'b1;
         end
         DP_HORNER_ACC: begin
            acc_ff <= horner_val;
            if (idx_ff != '0) begin
               q_ff[idx_ff - 1'b1] <= horner_val;
               idx_ff              <= idx_ff - 1'b1;
            end
         end
         DP_SAVE_V_PREV: begin
            v_prev_ff <= acc_ff;
            x_eval_ff <= x_cur_ff;
         end
         DP_SAVE_V_CUR: v_cur_ff <= acc_ff;
         DP_DEN: den_ff <= sat_sub(v_cur_ff, v_prev_ff);
         DP_DIV_START: begin
            dv_ff       <= mag(den_ff);
            corr_neg_ff <= mul_neg_ff ^ den_ff[WORD_W-1];
            rem_ff      <= '0;
            div_cnt_ff  <= '0;
         end
         DP_DIV_STEP: begin
            rem_ff     <= ge ? WORD_W'(rem_sh - {1'b0, dv_ff}) : rem_sh[WORD_W-1:0];
            prod_ff    <= {prod_ff[WIDE_W-2:0], ge};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         DP_NEXT: x_eval_ff <= x_next;
         DP_ADVANCE: begin
            x_prev_ff <= x_cur_ff;
            x_cur_ff  <= x_eval_ff;
            v_prev_ff <= v_cur_ff;
            v_cur_ff  <= acc_ff;
            steps_ff  <= steps_ff + 1'b1;
            conv_ff   <= mag(step) < {{(WORD_W-TOL_W){1'b0}}, tolerance_ff};
         end
         DP_EMIT_DEFLATE: begin
            rsp_data_ff <= {6'd0, root_ctr_ff, steps_ff, v_cur_ff, x_cur_ff};
            rsp_user_ff <= conv_ff;
            rsp_last_ff <= n_ff == IDX_W'(1);
            for (int i = 0; i < DEPTH; i++) begin
               if (IDX_W'(i) < n_ff) c_ff[i] <= q_ff[i];
            end
         end
         default: ;
      endcase
   end

   assign status.n_zero    = n_ff == '0;
   assign status.idx_zero  = idx_ff == '0;
   assign status.mul_last  = mul_k_ff == 2'd3;
   assign status.div_last  = div_cnt_ff == {DIV_CNT_W{1'b1}};
   assign status.den_zero  = den_ff == '0;
   assign status.limit_hit = steps_ff >= limit_ff;
   assign status.conv      = conv_ff;
   assign status.out_busy  = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("coefficient count past store depth");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_EMIT_DEFLATE |-> !rsp_valid_ff) else $error("result overwritten");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_EMIT_DEFLATE |=> rsp_valid_ff) else $error("result not presented");

endmodule

@@ sv/prfs_controller.sv @@
// Controller: sequences loading, Horner passes, secant steps and result emission.
module prfs_controller
   import prfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tlast,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   eval_phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PREV;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid && req_tlast) state_in = S_RUN;
         S_RUN:    state_in = S_ROOT;
         S_ROOT: begin
            phase_in = PH_PREV;
            state_in = status.n_zero ? S_IDLE : S_H_INIT;
         end
         S_H_INIT: state_in = S_H_MUL;
         S_H_MUL:  state_in = S_H_WAIT;
         S_H_WAIT: if (status.mul_last) state_in = S_H_ACC;
         S_H_ACC:  state_in = status.idx_zero ? S_SAVE : S_H_MUL;
         S_SAVE: begin
            unique case (phase_ff)
               PH_PREV: begin
                  phase_in = PH_CUR;
                  state_in = S_H_INIT;
               end
               PH_CUR:  state_in = S_CHECK;
               default: state_in = S_TEST;
            endcase
         end
         S_TEST:   state_in = status.conv ? S_EMIT : S_CHECK;
         S_CHECK:  state_in = S_CHECK2;
         S_CHECK2: state_in = (status.limit_hit || status.den_zero) ? S_EMIT : S_S_MUL;
         S_S_MUL:  state_in = S_S_WAIT;
         S_S_WAIT: if (status.mul_last) state_in = S_DIV_START;
         S_DIV_START: state_in = S_DIV;
         S_DIV:    if (status.div_last) state_in = S_NEXT;
         S_NEXT: begin
            phase_in = PH_NEXT;
            state_in = S_H_INIT;
         end
         S_EMIT:   if (!status.out_busy) state_in = S_ROOT;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.op         = DP_NONE;
      cmd.mul_secant = 1'b0;
      req_tready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = DP_LOAD;
         end
         S_RUN:    cmd.op = DP_RUN_START;
         S_ROOT:   if (!status.n_zero) cmd.op = DP_ROOT_INIT;
         S_H_INIT: cmd.op = DP_HORNER_INIT;
         S_H_MUL:  cmd.op = DP_MUL_START;
         S_H_WAIT, S_S_WAIT: cmd.op = DP_MUL_STEP;
         S_H_ACC:  cmd.op = DP_HORNER_ACC;
         S_SAVE: begin
            unique case (phase_ff)
               PH_PREV: cmd.op = DP_SAVE_V_PREV;
               PH_CUR:  cmd.op = DP_SAVE_V_CUR;
               default: cmd.op = DP_ADVANCE;
            endcase
         end
         S_CHECK:  cmd.op = DP_DEN;
         S_S_MUL: begin
            cmd.op         = DP_MUL_START;
            cmd.mul_secant = 1'b1;
         end
         S_DIV_START: cmd.op = DP_DIV_START;
         S_DIV:    cmd.op = DP_DIV_STEP;
         S_NEXT:   cmd.op = DP_NEXT;
         S_EMIT:   if (!status.out_busy) cmd.op = DP_EMIT_DEFLATE;
         default:  cmd.op = DP_NONE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("request taken while busy");
   a_last_runs: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> state_ff == S_RUN)
      else $error("last request did not start search");
   a_emit_path: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_EMIT_DEFLATE |=> state_ff == S_ROOT) else $error("emit not followed by root");

endmodule
